// ----- src/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// shared widths, types and constants of the sliding window median unit
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int MAX_WINDOW   = 32;
   localparam int SAMPLE_BITS  = 16;
   localparam int MED_BITS     = SAMPLE_BITS + 1;
   localparam int IDX_BITS     = $clog2(MAX_WINDOW);
   localparam int CNT_BITS     = $clog2(MAX_WINDOW + 1);
   localparam int CFG_BITS     = 6;
   localparam int RESET_WINDOW = 3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [MED_BITS-1:0]    med_type;
   typedef logic [IDX_BITS-1:0]           age_type;
   typedef logic [CNT_BITS-1:0]           cnt_type;
   typedef logic [CFG_BITS-1:0]           cfg_type;

   // one sorted entry: value and its age in beats
   typedef struct packed {
      sample_type value;
      age_type    age;
   } entry_type;

   // common control for all cells
   typedef struct packed {
      logic    upd;
      logic    full;
      age_type age_top;
   } cell_ctl_type;

   // left to right link between neighbor cells
   typedef struct packed {
      logic      removed;
      logic      keep_left;
      entry_type ent;
   } link_type;

endpackage

// ----- src/sliding_window_median_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// running median of the last k signed samples, reported as twice the median
// ----------------------------------------------------------------------------
//
//   channel   ports                                   direction  beat
//   request   req_valid/ready, sample, start_of_seq   in         one sample
//   response  rsp_valid/ready, median_times_two       out        one median
//   csr       csr_wr_en, csr_wr_data                  in         window size
//
// one sample beat per clock while req_ready is high; the whole cell row
// compares and shifts in the accepting cycle, the median is taken from the
// row into the output register once that register is free
// reset sets the window size to 3 and empties the window
// the cells keep one pending median while the output register holds another;
// req_ready drops only when both are occupied and rsp_ready is low
// a csr write empties the window
// ----------------------------------------------------------------------------
module sliding_window_median_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  swm_pkg::sample_type    req_sample,
   input  logic                   req_start_of_sequence,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output swm_pkg::med_type       rsp_median_times_two,
   input  logic                   csr_wr_en,
   input  swm_pkg::cfg_type       csr_wr_data
);
   import swm_pkg::*;

   // window size register and fill state
   cfg_type   win_ff;
   cfg_type   win_in;
   cnt_type   fill_ff;
   cnt_type   fill_in;
   logic      pend_ff;
   logic      pend_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   med_type   rsp_med_ff;

   cnt_type      k;
   cnt_type      fill_eff;
   cnt_type      n_kept;
   logic         full;
   logic         emit;
   logic         out_free;
   logic         move;
   logic         accept;
   cell_ctl_type ctl;
   med_type      med;

   entry_type cur     [MAX_WINDOW];
   link_type  links   [MAX_WINDOW+1];
   entry_type right   [MAX_WINDOW];
   logic      in_win  [MAX_WINDOW];
   logic      live    [MAX_WINDOW];

   // window size zero acts as one, oversize saturates
   function automatic cnt_type eff_window(input cfg_type w);
      cnt_type r;
      if (w == '0) begin
         r = cnt_type'(1);
      end else if (int'(w) > MAX_WINDOW) begin
         r = cnt_type'(MAX_WINDOW);
      end else begin
         r = cnt_type'(w);
      end
      return r;
   endfunction

   assign k = eff_window(win_ff);

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign move      = pend_ff && out_free;
   assign req_ready = !pend_ff || out_free;
   assign accept    = req_valid && req_ready;

   // start of sequence empties the window before the sample goes in
   assign fill_eff = req_start_of_sequence ? '0 : fill_ff;
   assign full     = (fill_eff == k);
   assign n_kept   = full ? (k - cnt_type'(1)) : fill_eff;
   assign emit     = full || ((fill_eff + cnt_type'(1)) == k);

   assign ctl.upd     = accept;
   assign ctl.full    = full;
   assign ctl.age_top = age_type'(k - cnt_type'(1));

   // leftmost cell sees an always smaller neighbor and no removal
   assign links[0].removed   = 1'b0;
   assign links[0].keep_left = 1'b1;
   assign links[0].ent       = '0;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      assign in_win[i] = (cnt_type'(i) < fill_eff);
      assign live[i]   = (cnt_type'(i) < n_kept);
      if (i == MAX_WINDOW - 1) begin : g_last
         assign right[i] = cur[i];
      end else begin : g_mid
         assign right[i] = cur[i+1];
      end

      swm_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .in_window (in_win[i]),
         .live      (live[i]),
         .sample    (req_sample),
         .link_in   (links[i]),
         .right_cur (right[i]),
         .link_out  (links[i+1]),
         .cur       (cur[i])
      );
   end

   // median of the row as it stands before this edge's update
   swm_tap_sum u_tap (
      .cells (cur),
      .k     (k),
      .med   (med)
   );

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      if (csr_wr_en) begin
         win_in  = csr_wr_data;
         fill_in = '0;
      end else if (accept) begin
         fill_in = full ? k : (fill_eff + cnt_type'(1));
      end
   end

   always_comb begin
      if (accept) begin
         pend_in = emit;
      end else if (move) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= cfg_type'(RESET_WINDOW);
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload, no reset needed
   always_ff @(posedge clock) begin
      if (move) begin
         rsp_med_ff <= med;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_median_times_two = rsp_med_ff;

endmodule

// ----- src/swm_cell.sv -----
// ----------------------------------------------------------------------------
// swm_cell
// one slot of the sorted window: drops the oldest entry, inserts the new sample
// ----------------------------------------------------------------------------
module swm_cell (
   input  logic                 clock,
   input  swm_pkg::cell_ctl_type ctl,
   input  logic                 in_window,
   input  logic                 live,
   input  swm_pkg::sample_type  sample,
   input  swm_pkg::link_type    link_in,
   input  swm_pkg::entry_type   right_cur,
   output swm_pkg::link_type    link_out,
   output swm_pkg::entry_type   cur
);
   import swm_pkg::*;

   entry_type ent_ff;
   entry_type ent_in;
   entry_type packed_ent;
   logic      rm;
   logic      removed;
   logic      keep_left;

   // this cell holds the oldest sample of a full window
   assign rm      = ctl.full && in_window && (ent_ff.age == ctl.age_top);
   assign removed = link_in.removed || rm;

   // entry at this place once the oldest is gone
   assign packed_ent = removed ? right_cur : ent_ff;
   assign keep_left  = live && (packed_ent.value <= sample);

   always_comb begin
      if (keep_left) begin
         ent_in.value = packed_ent.value;
         ent_in.age   = packed_ent.age + age_type'(1);
      end else if (link_in.keep_left) begin
         ent_in.value = sample;
         ent_in.age   = '0;
      end else begin
         ent_in.value = link_in.ent.value;
         ent_in.age   = link_in.ent.age + age_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.upd) begin
         ent_ff <= ent_in;
      end
   end

   assign link_out.removed   = removed;
   assign link_out.keep_left = keep_left;
   assign link_out.ent       = packed_ent;
   assign cur                = ent_ff;

endmodule

// ----- src/swm_tap_sum.sv -----
// ----------------------------------------------------------------------------
// swm_tap_sum
// picks the middle entries of the sorted row and forms twice the median
// ----------------------------------------------------------------------------
module swm_tap_sum (
   input  swm_pkg::entry_type cells [swm_pkg::MAX_WINDOW],
   input  swm_pkg::cnt_type   k,
   output swm_pkg::med_type   med
);
   import swm_pkg::*;

   cnt_type    half;
   age_type    hi_idx;
   age_type    lo_idx;
   sample_type hi_val;
   sample_type lo_val;
   sample_type a_val;

   assign half   = k >> 1;
   assign hi_idx = half[IDX_BITS-1:0];
   assign lo_idx = hi_idx - age_type'(1);
   assign hi_val = cells[hi_idx].value;
   assign lo_val = cells[lo_idx].value;

   // odd window doubles the middle, even window adds the two middles
   assign a_val = k[0] ? hi_val : lo_val;
   assign med   = med_type'(a_val) + med_type'(hi_val);

endmodule

// ----- sim/swm_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swm_checker
// watches the sample, median and csr ports of the median unit, keeps its own
// window model and compares every median beat with the predicted value
// ----------------------------------------------------------------------------
module swm_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  swm_pkg::sample_type req_sample,
   input  logic                req_start_of_sequence,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  swm_pkg::med_type    rsp_median_times_two,
   input  logic                csr_wr_en,
   input  swm_pkg::cfg_type    csr_wr_data,
   output int                  fail_count,
   output int                  pending,
   output int                  medians_checked
);
   import swm_pkg::*;

   cfg_type win_len;
   int      arrival [MAX_WINDOW];
   int      ordered [MAX_WINDOW];
   int      oldest_slot;
   int      held;
   int      errors;
   int      checked;
   med_type median_q [$];

   function automatic int active_len();
      if (win_len == 0) return 1;
      if (win_len > MAX_WINDOW) return MAX_WINDOW;
      return int'(win_len);
   endfunction

   function automatic void drop_ordered(int n, int v);
      int p;
      p = 0;
      while (p < n && ordered[p] != v) p++;
      if (p >= n) return;
      while (p + 1 < n) begin
         ordered[p] = ordered[p + 1];
         p++;
      end
   endfunction

   function automatic void insert_ordered(int n, int v);
      int p;
      if (n >= MAX_WINDOW) return;
      p = n;
      while (p > 0 && ordered[p - 1] > v) begin
         ordered[p] = ordered[p - 1];
         p--;
      end
      ordered[p] = v;
   endfunction

   // slide one sample into the window, returns 1 when a median is due
   function automatic bit slide_window(int s, logic restart, output med_type med);
      int k;
      int gone;
      int sum;
      k = active_len();
      med = '0;
      if (restart) begin
         oldest_slot = 0;
         held = 0;
      end
      if (held > k) begin
         held = 0;
         oldest_slot = 0;
      end
      if (oldest_slot >= k) oldest_slot = 0;
      if (held < k) begin
         arrival[held] = s;
         insert_ordered(held, s);
         held++;
      end else begin
         gone = arrival[oldest_slot];
         drop_ordered(k, gone);
         insert_ordered(k - 1, s);
         arrival[oldest_slot] = s;
         oldest_slot++;
         if (oldest_slot >= k) oldest_slot = 0;
      end
      if (held < k) return 1'b0;
      if (k % 2 == 1) sum = 2 * ordered[k / 2];
      else sum = ordered[k / 2 - 1] + ordered[k / 2];
      med = med_type'(sum);
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      med_type want;
      med_type next_med;
      if (reset) begin
         win_len = cfg_type'(RESET_WINDOW);
         oldest_slot = 0;
         held = 0;
         errors = 0;
         checked = 0;
         median_q.delete();
      end else begin
         if (csr_wr_en) begin
            win_len = csr_wr_data;
            oldest_slot = 0;
            held = 0;
         end
         if (rsp_valid && rsp_ready) begin
            if (median_q.size() == 0) begin
               $display("%0t: unexpected median beat, expected none, actual %0d",
                        $time, rsp_median_times_two);
               errors++;
            end else begin
               want = median_q.pop_front();
               checked++;
               if (rsp_median_times_two !== want) begin
                  $display("%0t: median mismatch, expected %0d, actual %0d",
                           $time, want, rsp_median_times_two);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (slide_window(int'(req_sample), req_start_of_sequence, next_med))
               median_q.push_back(next_med);
         end
      end
      fail_count      <= errors;
      medians_checked <= checked;
      pending         <= median_q.size();
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives sample beats, window size writes and median back-pressure into the
// median unit; a separate checker predicts and compares every median beat
// ----------------------------------------------------------------------------
module tb_top;
   import swm_pkg::*;

   localparam int SETTLE_CYCLES = 4;     // slack after the last median before a csr write
   localparam int LONG_HOLD     = 80;    // long receiver hold-off, in cycles
   localparam int STALL_LIMIT   = 1000;  // cycles without any beat before giving up
   localparam int PHASE_ITEMS   = 70;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   sample_type req_sample;
   logic       req_start_of_sequence;
   logic       rsp_valid;
   logic       rsp_ready;
   med_type    rsp_median_times_two;
   logic       csr_wr_en;
   cfg_type    csr_wr_data;

   int         fail_count;
   int         pending;
   int         medians_checked;

   // receiver control, set from the stimulus process
   int         stall_pct = 0;
   logic       long_hold_req = 1'b0;
   logic       long_hold_done = 1'b0;

   int         samples_sent = 0;
   int         windows_set = 0;
   int         quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sliding_window_median_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sample            (req_sample),
      .req_start_of_sequence (req_start_of_sequence),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_median_times_two  (rsp_median_times_two),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   swm_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sample            (req_sample),
      .req_start_of_sequence (req_start_of_sequence),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_median_times_two  (rsp_median_times_two),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .fail_count            (fail_count),
      .pending               (pending),
      .medians_checked       (medians_checked)
   );

   // median receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !long_hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog: nothing moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("sliding_window_median_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // mostly full-range samples, some near zero for ties, some at the rails
   function automatic sample_type pick_sample();
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         case ($urandom_range(3))
            0:       return sample_type'(-32768);
            1:       return sample_type'(32767);
            2:       return sample_type'(-1);
            default: return sample_type'(0);
         endcase
      end
      if (r <= 3) return sample_type'(int'($urandom_range(8)) - 4);
      return sample_type'($urandom);
   endfunction

   // hold the sample beat until the unit takes it
   task automatic send_sample(sample_type s, logic restart);
      req_valid             <= 1'b1;
      req_sample            <= s;
      req_start_of_sequence <= restart;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   // wait until every predicted median has been taken
   task automatic drain_results();
      do @(posedge clock); while (pending != 0);
   endtask

   // window size write, only once the unit has gone quiet
   task automatic write_window(cfg_type len);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      windows_set++;
   endtask

   // a run of random samples; pause_at < 0 means no mid-run drain
   task automatic run_samples(int count, int send_idle, int restart_pct, int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) begin
            req_valid <= 1'b0;
            drain_results();
         end
         while ($urandom_range(99) < send_idle) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         send_sample(pick_sample(), $urandom_range(99) < restart_pct);
      end
      req_valid <= 1'b0;
   endtask

   initial begin : stimulus
      // directed beats; a window entry >= 0 writes that size first
      int   dir_val [23] = '{32767, -32768, 0, -32768, -32768, 32767, 32767, 32767,
                             5, 5, -1, 7, -1, 2, 3,
                             -32768, -32767, 32767, 32767, -7,
                             1234, -32768, 32767};
      logic dir_restart [23] = '{1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 1, 0, 0,
                                 0, 0, 0, 0, 1, 0, 1, 0};
      int   dir_win [23] = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1,
                             2, -1, -1, -1, -1, 0, -1, -1};
      // window sizes of the random phases: extremes, saturation and ordinary ones
      int   phase_win [16] = '{1, 2, 0, 32, 33, 63, 31, 5, 4, 3, 7, 16, 8, 2, 17, 32};
      int   send_idle;
      int   restart_pct;

      reset                 <= 1'b1;
      req_valid             <= 1'b0;
      req_sample            <= '0;
      req_start_of_sequence <= 1'b0;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: rails in and out, ties, restarts during fill, odd sums,
      // even window, zero size, all at full rate on the reset window first
      for (int i = 0; i < 23; i++) begin
         if (dir_win[i] >= 0) begin
            req_valid <= 1'b0;
            write_window(cfg_type'(dir_win[i]));
         end
         send_sample(sample_type'(dir_val[i]), dir_restart[i]);
      end
      req_valid <= 1'b0;

      // random phases, cycling the idle pattern on both sides
      for (int p = 0; p < 16; p++) begin
         write_window(cfg_type'(phase_win[p]));
         case (p % 4)
            0: begin send_idle = 0;  stall_pct <= 0;  end
            1: begin send_idle = 55; stall_pct <= 0;  end
            2: begin send_idle = 0;  stall_pct <= 55; end
            default: begin send_idle = 29; stall_pct <= 29; end
         endcase
         // frequent restarts only where the window is short enough to refill
         restart_pct = (phase_win[p] != 0 && phase_win[p] <= 8 && p % 3 == 0) ? 15 : 2;
         run_samples(PHASE_ITEMS, send_idle, restart_pct, (p == 6) ? 35 : -1);
      end

      // back-pressure: receiver holds off while samples keep coming, so the
      // unit fills both median slots and drops req_ready
      write_window(cfg_type'(4));
      stall_pct     <= 0;
      long_hold_req <= 1'b1;
      run_samples(24, 0, 0, -1);

      drain_results();
      repeat (8) @(posedge clock);
      $display("run covered %0d sample beats, %0d checked medians, %0d window size writes",
               samples_sent, medians_checked, windows_set);
      $display("window sizes 0 to 63 incl. saturation, restarts, rails and a long receiver hold");
      if (fail_count == 0 && pending == 0) begin
         $display("sliding_window_median_unit verification clean");
      end else begin
         $display("sliding_window_median_unit verification failed");
      end
      $finish;
   end

endmodule
